// File: rtl/core/i2cm_pkg.sv
// Shared types and codes for the I2C master bit sequencer.
package i2cm_pkg;

  // Command codes carried in the kind field
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_SEND  = 3'd3;
  localparam logic [2:0] KIND_WACK  = 3'd4;
  localparam logic [2:0] KIND_READ  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_POLL_IVAL   = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT  = 2'd2;

  // Register reset values
  localparam logic [15:0] HALF_PERIOD_RST = 16'd2;
  localparam logic [15:0] POLL_IVAL_RST   = 16'd1;
  localparam logic [7:0]  POLL_LIMIT_RST  = 8'd100;

  // Bit sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST1  = 5'd1,
    PH_ST2  = 5'd2,
    PH_ST3  = 5'd3,
    PH_SP1  = 5'd4,
    PH_SP2  = 5'd5,
    PH_SP3  = 5'd6,
    PH_WA1  = 5'd7,
    PH_WA2  = 5'd8,
    PH_WAP  = 5'd9,
    PH_WAE  = 5'd10,
    PH_SBA  = 5'd11,
    PH_SBB  = 5'd12,
    PH_SBC  = 5'd13,
    PH_RBA  = 5'd14,
    PH_RBB  = 5'd15,
    PH_RK1  = 5'd16,
    PH_RK2  = 5'd17,
    PH_RK3  = 5'd18
  } phase_e;

  // Effective configuration, zero values already forced to one
  typedef struct packed {
    logic [15:0] half_ticks;
    logic [15:0] poll_ticks;
    logic [7:0]  poll_limit;
  } cfg_t;

  // One input word
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_t;

  // One result word
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;
  } res_t;

endpackage

// File: rtl/core/i2cm_if.sv
// Valid/ready channel interfaces for the command and result words.
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, kind, data_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, kind, data_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       no_ack;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_data, no_ack, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_data, no_ack, output ready);
endinterface

// File: rtl/core/i2cm_cfg_regs.sv
// Configuration registers with zero-to-one clamping of the timing values.
module i2cm_cfg_regs
  import i2cm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  logic [15:0] half_q;
  logic [15:0] poll_q;
  logic [7:0]  limit_q;

  // Write the addressed register, drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= HALF_PERIOD_RST;
      poll_q  <= POLL_IVAL_RST;
      limit_q <= POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HALF_PERIOD: half_q  <= cfg_wdata_i;
        CFG_POLL_IVAL:   poll_q  <= cfg_wdata_i;
        CFG_POLL_LIMIT:  limit_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Treat a zero setting as one
  always_comb begin
    cfg_o.half_ticks = (half_q == 16'd0) ? 16'd1 : half_q;
    cfg_o.poll_ticks = (poll_q == 16'd0) ? 16'd1 : poll_q;
    cfg_o.poll_limit = (limit_q == 8'd0) ? 8'd1 : limit_q;
  end

endmodule

// File: rtl/core/i2cm_core.sv
// Bus sequencer state and its one-tick update, producing one result per word.
module i2cm_core
  import i2cm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic step_i,
  input  cmd_t cmd_i,
  output res_t res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] timer_q, timer_d;
  logic [3:0]  bits_q, bits_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  polls_q, polls_d;
  logic        ack_q, ack_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drive_q, drive_d;
  logic        nack_q, nack_d;
  logic [7:0]  rx_q, rx_d;
  logic        done;
  logic [3:0]  bits_inc;
  logic [7:0]  polls_inc;

  assign bits_inc  = bits_q + 4'd1;
  assign polls_inc = polls_q + 8'd1;

  // Hold the sequencer state, advance one tick per accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= 16'd0;
      bits_q  <= 4'd0;
      shift_q <= 8'd0;
      polls_q <= 8'd0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drive_q <= 1'b0;
      nack_q  <= 1'b0;
      rx_q    <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      polls_q <= polls_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drive_q <= drive_d;
      nack_q  <= nack_d;
      rx_q    <= rx_d;
    end
  end

  // Next state: take a command when idle, else count down or run the next action
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    polls_d = polls_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drive_d = drive_q;
    nack_d  = nack_q;
    rx_d    = rx_q;
    done    = 1'b0;

    if (phase_q == PH_IDLE) begin
      unique case (cmd_i.kind)
        KIND_START: begin
          drive_d = 1'b1;
          sda_d   = 1'b1;
          scl_d   = 1'b1;
          phase_d = PH_ST1;
          timer_d = cfg_i.half_ticks;
        end
        KIND_STOP: begin
          drive_d = 1'b1;
          sda_d   = 1'b0;
          phase_d = PH_SP1;
          timer_d = cfg_i.half_ticks;
        end
        KIND_SEND: begin
          drive_d = 1'b1;
          shift_d = cmd_i.data_byte;
          bits_d  = 4'd0;
          sda_d   = cmd_i.data_byte[7];
          phase_d = PH_SBA;
          timer_d = cfg_i.half_ticks;
        end
        KIND_WACK: begin
          drive_d = 1'b0;
          sda_d   = 1'b1;
          polls_d = 8'd0;
          phase_d = PH_WA1;
          timer_d = cfg_i.half_ticks;
        end
        KIND_READ: begin
          drive_d = 1'b0;
          sda_d   = 1'b1;
          shift_d = 8'd0;
          bits_d  = 4'd0;
          ack_d   = cmd_i.send_ack;
          scl_d   = 1'b1;
          phase_d = PH_RBA;
          timer_d = cfg_i.half_ticks;
        end
        default: ;
      endcase
    end else if (timer_q <= 16'd1) begin
      timer_d = cfg_i.half_ticks;
      unique case (phase_q)
        PH_ST1: begin sda_d = 1'b0; phase_d = PH_ST2; end
        PH_ST2: begin scl_d = 1'b0; phase_d = PH_ST3; end
        PH_SP1: begin scl_d = 1'b1; phase_d = PH_SP2; end
        PH_SP2: begin sda_d = 1'b1; phase_d = PH_SP3; end
        PH_WA1: begin scl_d = 1'b1; phase_d = PH_WA2; end
        PH_WA2, PH_WAP: begin
          if (!cmd_i.sda_in) begin
            nack_d  = 1'b0;
            scl_d   = 1'b0;
            phase_d = PH_WAE;
          end else begin
            polls_d = polls_inc;
            if (polls_inc >= cfg_i.poll_limit) begin
              nack_d  = 1'b1;
              scl_d   = 1'b0;
              phase_d = PH_WAE;
            end else begin
              phase_d = PH_WAP;
              timer_d = cfg_i.poll_ticks;
            end
          end
        end
        PH_SBA: begin scl_d = 1'b1; phase_d = PH_SBB; end
        PH_SBB: begin
          scl_d = 1'b0;
          if (bits_q == 4'd7) sda_d = 1'b1;
          shift_d = {shift_q[6:0], 1'b0};
          phase_d = PH_SBC;
        end
        PH_SBC: begin
          bits_d = bits_inc;
          if (bits_inc >= 4'd8) begin
            phase_d = PH_IDLE;
            timer_d = 16'd0;
            done    = 1'b1;
          end else begin
            sda_d   = shift_q[7];
            phase_d = PH_SBA;
          end
        end
        PH_RBA: begin
          shift_d = {shift_q[6:0], cmd_i.sda_in};
          scl_d   = 1'b0;
          phase_d = PH_RBB;
        end
        PH_RBB: begin
          bits_d = bits_inc;
          if (bits_inc >= 4'd8) begin
            rx_d    = shift_q;
            drive_d = 1'b1;
            sda_d   = !ack_q;
            phase_d = PH_RK1;
          end else begin
            scl_d   = 1'b1;
            phase_d = PH_RBA;
          end
        end
        PH_RK1: begin scl_d = 1'b1; phase_d = PH_RK2; end
        PH_RK2: begin scl_d = 1'b0; phase_d = PH_RK3; end
        PH_RK3: begin
          if (ack_q) sda_d = 1'b1;
          phase_d = PH_IDLE;
          timer_d = 16'd0;
          done    = 1'b1;
        end
        default: begin
          // end of stop, start and ack-wait sequences
          phase_d = PH_IDLE;
          timer_d = 16'd0;
          done    = 1'b1;
        end
      endcase
    end else begin
      timer_d = timer_q - 16'd1;
    end
  end

  // Report the levels after this tick's update
  always_comb begin
    res_o.scl_level = scl_d;
    res_o.sda_level = sda_d;
    res_o.sda_drive = drive_d;
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.read_data = rx_d;
    res_o.no_ack    = nack_d;
  end

endmodule

// File: rtl/core/i2cm_out_reg.sv
// Result register that parts the command side from a stalling receiver.
module i2cm_out_reg
  import i2cm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic take_i,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  // Track whether a result word is waiting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the payload on load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: rtl/core/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer.
// Each command word is one timing tick: it carries the sampled SDA level and,
// when the sequencer is idle, a command (start, stop, send byte, wait ack,
// read byte). Commands that arrive while busy are ignored.
// Every accepted word yields exactly one result word with the SCL level, SDA
// level and drive enable after that tick, plus busy, done, read byte and
// no-ack status. The result is registered and appears in the cycle after the word is accepted.
// Throughput is one word per cycle: the sequencer state updates in a single
// pass of logic per tick, and a single result register sits at the output.
// When the receiver stalls with a result waiting, ready drops and the state
// holds until the result is taken; the taking cycle accepts a new word.
// Reset puts the bus lines high with SDA released, the sequencer idle and
// the timing registers at half period 2, poll interval 1 and poll limit 100.
// Configuration writes through cfg_we_i/cfg_idx_i/cfg_wdata_i take effect on
// the next tick and are meant to be done while the sequencer is idle.
module i2c_master_bit_sequencer
  import i2cm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  i2cm_in_if.sink     in_ch,
  i2cm_out_if.source  out_ch
);

  cfg_t cfg;
  cmd_t cmd;
  res_t res_next;
  res_t res_out;
  logic out_valid;
  logic in_ready;
  logic in_accept;

  // Accept a word whenever the result slot is free or being emptied
  assign in_ready  = !out_valid || out_ch.ready;
  assign in_accept = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign cmd.kind      = in_ch.kind;
  assign cmd.data_byte = in_ch.data_byte;
  assign cmd.send_ack  = in_ch.send_ack;
  assign cmd.sda_in    = in_ch.sda_in;

  i2cm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  i2cm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (in_accept),
    .cmd_i  (cmd),
    .res_o  (res_next)
  );

  i2cm_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_accept),
    .res_i   (res_next),
    .take_i  (out_ch.ready),
    .valid_o (out_valid),
    .res_o   (res_out)
  );

  // Drive the result channel
  assign out_ch.valid     = out_valid;
  assign out_ch.scl_level = res_out.scl_level;
  assign out_ch.sda_level = res_out.sda_level;
  assign out_ch.sda_drive = res_out.sda_drive;
  assign out_ch.busy_res  = res_out.busy_res;
  assign out_ch.done_res  = res_out.done_res;
  assign out_ch.read_data = res_out.read_data;
  assign out_ch.no_ack    = res_out.no_ack;

  // An accepted word always leaves a result behind
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid)
    else $error("accepted word produced no result");

  // Input stalls only while a result waits on a stalled receiver
  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ch.ready))
    else $error("input stalled without a blocked result");

  // A completing tick reports the sequencer idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && res_next.done_res) |=> !out_ch.busy_res)
    else $error("done pulse while still busy");

endmodule
